/* design/cga_pkg.sv */
// ----------------------------------------------------------------------------
// cga_pkg
// Shared types, register indexes and the fixed 16-entry palette of the
// CGA pixel generator.
// ----------------------------------------------------------------------------
package cga_pkg;

    localparam int LANES     = 16;
    localparam int CFG_AW    = 2;
    localparam int CFG_DW    = 6;

    localparam logic [CFG_AW-1:0] REG_MODE_CONTROL = 2'd0;
    localparam logic [CFG_AW-1:0] REG_COLOR_SELECT = 2'd1;
    localparam logic [CFG_AW-1:0] REG_CURSOR_START = 2'd2;
    localparam logic [CFG_AW-1:0] REG_CURSOR_END   = 2'd3;

    typedef enum logic [1:0] {
        MODE_TEXT,
        MODE_MED,
        MODE_HI
    } video_mode_t;

    typedef struct packed {
        logic [7:0] byte_a;
        logic [7:0] byte_b;
        logic [4:0] row_in_cell;
        logic       cursor_here;
        logic       blink_phase;
        logic       display_active;
    } cell_beat_t;

    typedef struct packed {
        logic [23:0] pixel_rgb;
        logic [3:0]  color_index;
        logic        last_pixel;
    } pixel_beat_t;

    typedef struct packed {
        video_mode_t mode;
        logic [3:0]  color;
        logic        intense;
        logic        pal_sel;
        logic        mono;
        logic [3:0]  fg;
        logic [3:0]  bg;
        logic        show;
        logic        cline;
    } lane_ctrl_t;

    function automatic logic [23:0] pal_rgb(input logic [3:0] idx);
        logic [23:0] rgb;
        case (idx)
            4'd0:    rgb = 24'h000000;
            4'd1:    rgb = 24'h0000AA;
            4'd2:    rgb = 24'h00AA00;
            4'd3:    rgb = 24'h00AAAA;
            4'd4:    rgb = 24'hAA0000;
            4'd5:    rgb = 24'hAA00AA;
            4'd6:    rgb = 24'hAA5500;
            4'd7:    rgb = 24'hAAAAAA;
            4'd8:    rgb = 24'h555555;
            4'd9:    rgb = 24'h5555FF;
            4'd10:   rgb = 24'h55FF55;
            4'd11:   rgb = 24'h55FFFF;
            4'd12:   rgb = 24'hFF5555;
            4'd13:   rgb = 24'hFF55FF;
            4'd14:   rgb = 24'hFFFF55;
            default: rgb = 24'hFFFFFF;
        endcase
        return rgb;
    endfunction

endpackage

/* design/cga_lane.sv */
// ----------------------------------------------------------------------------
// cga_lane
// Colour index of one pixel position of a cell scanline, for text,
// 320-wide and 640-wide modes.
// ----------------------------------------------------------------------------
module cga_lane (
    input  cga_pkg::lane_ctrl_t ctrl,
    input  logic                hi_bit,
    input  logic [1:0]          pair,
    output logic [3:0]          idx
);
    import cga_pkg::*;

    always_comb
    begin
        case (ctrl.mode)
            MODE_HI:
            begin
                idx = hi_bit ? ctrl.color : 4'd0;
            end
            MODE_MED:
            begin
                if (pair == 2'd0)
                begin
                    idx = ctrl.color;
                end
                else
                begin
                    idx = {ctrl.intense, pair, ctrl.mono ? pair[0] : ctrl.pal_sel};
                end
            end
            default:
            begin
                idx = ((ctrl.show && hi_bit) || ctrl.cline) ? ctrl.fg : ctrl.bg;
            end
        endcase
    end

endmodule

/* design/cga_serial.sv */
// ----------------------------------------------------------------------------
// cga_serial
// Holds one decoded cell of lane results and shifts its pixels out one
// beat per out_ready cycle while the next cell waits in the hold register.
// ----------------------------------------------------------------------------
module cga_serial (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  load_valid,
    output logic                                  load_ready,
    input  logic [cga_pkg::LANES-1:0][3:0]        load_idx,
    input  logic                                  load_wide,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output cga_pkg::pixel_beat_t                  out_data
);
    import cga_pkg::*;

    localparam int PW = $clog2(LANES);

    logic                     hold_valid_reg, hold_valid_next;
    logic [LANES-1:0][3:0]    hold_idx_reg;
    logic                     hold_wide_reg;
    logic                     ser_valid_reg, ser_valid_next;
    logic [LANES-1:0][3:0]    ser_idx_reg;
    logic                     ser_wide_reg;
    logic [PW-1:0]            pos_reg, pos_next;
    logic [PW-1:0]            last_pos;
    logic                     is_last;
    logic                     ser_done;
    logic                     ser_free;
    logic                     hold_load;
    logic                     ser_load;
    logic [3:0]               cur_idx;

    assign last_pos   = ser_wide_reg ? PW'(LANES - 1) : PW'(LANES / 2 - 1);
    assign is_last    = (pos_reg == last_pos);
    assign ser_done   = ser_valid_reg && out_ready && is_last;
    assign ser_free   = !ser_valid_reg || ser_done;
    assign ser_load   = ser_free && hold_valid_reg;
    assign load_ready = !hold_valid_reg;
    assign hold_load  = load_valid && load_ready;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (ser_load)
        begin
            hold_valid_next = 1'b0;
        end
        if (hold_load)
        begin
            hold_valid_next = 1'b1;
        end
    end

    always_comb
    begin
        ser_valid_next = ser_valid_reg;
        pos_next       = pos_reg;
        if (ser_free)
        begin
            ser_valid_next = hold_valid_reg;
            pos_next       = '0;
        end
        else if (out_ready)
        begin
            pos_next = pos_reg + PW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            ser_valid_reg  <= 1'b0;
            pos_reg        <= '0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            ser_valid_reg  <= ser_valid_next;
            pos_reg        <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hold_load)
        begin
            hold_idx_reg  <= load_idx;
            hold_wide_reg <= load_wide;
        end
        if (ser_load)
        begin
            ser_idx_reg  <= hold_idx_reg;
            ser_wide_reg <= hold_wide_reg;
        end
    end

    assign cur_idx              = ser_idx_reg[pos_reg];
    assign out_valid            = ser_valid_reg;
    assign out_data.color_index = cur_idx;
    assign out_data.pixel_rgb   = pal_rgb(cur_idx);
    assign out_data.last_pixel  = is_last;

    a_narrow_stays_low: assert property (@(posedge clk) disable iff (!rst_n)
        (ser_valid_reg && !ser_wide_reg) |-> (pos_reg < PW'(LANES / 2)))
        else $error("narrow cell ran past its eighth pixel");

    a_cell_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !out_data.last_pixel) |=> out_valid)
        else $error("cell dropped before its last pixel");

    a_hold_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (hold_valid_reg && !ser_valid_reg) |=> (ser_valid_reg && pos_reg == '0))
        else $error("held cell not moved into idle serializer");

    a_pos_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (ser_done && hold_valid_reg) |=> (ser_valid_reg && pos_reg == '0))
        else $error("next cell did not start at its first pixel");

endmodule

/* design/cga_pixel_generator.sv */
// ----------------------------------------------------------------------------
// cga_pixel_generator
// Turns one character-cell scanline per beat into CGA pixels.
// ----------------------------------------------------------------------------
// Each input beat is decoded by sixteen pixel lanes in the cycle it is
// accepted and parked in a hold register; from there it moves to the output
// serializer, which sends one pixel beat per cycle: 8 pixels in text and
// 320-wide modes, 16 in 640-wide mode. A new cell is accepted while the
// previous one is still being sent, giving a steady one pixel per clock when
// out_ready stays high. Cells outside the display area or with video
// disabled are accepted and produce no pixels. When the output is idle, an
// accepted cell moves from the hold register into the serializer before its
// first pixel appears.
// ----------------------------------------------------------------------------
module cga_pixel_generator (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [cga_pkg::CFG_AW-1:0]      cfg_addr,
    input  logic [cga_pkg::CFG_DW-1:0]      cfg_wdata,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  cga_pkg::cell_beat_t             in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output cga_pkg::pixel_beat_t            out_data
);
    import cga_pkg::*;

    logic [5:0]            mode_control_reg;
    logic [5:0]            color_select_reg;
    logic [4:0]            cursor_start_reg;
    logic [4:0]            cursor_end_reg;
    lane_ctrl_t            ctrl;
    logic [15:0]           bits;
    logic                  blink_attr;
    logic                  blinking;
    logic                  blank;
    logic [LANES-1:0][3:0] lane_idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_control_reg <= '0;
            color_select_reg <= '0;
            cursor_start_reg <= '0;
            cursor_end_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_MODE_CONTROL: mode_control_reg <= cfg_wdata;
                REG_COLOR_SELECT: color_select_reg <= cfg_wdata;
                REG_CURSOR_START: cursor_start_reg <= cfg_wdata[4:0];
                REG_CURSOR_END:   cursor_end_reg   <= cfg_wdata[4:0];
                default:          ;
            endcase
        end
    end

    assign bits       = {in_data.byte_a, in_data.byte_b};
    assign blink_attr = mode_control_reg[5];
    assign blinking   = blink_attr && in_data.byte_b[7];
    assign blank      = !mode_control_reg[3] || !in_data.display_active;

    always_comb
    begin
        if (mode_control_reg[4])
        begin
            ctrl.mode = MODE_HI;
        end
        else if (mode_control_reg[1])
        begin
            ctrl.mode = MODE_MED;
        end
        else
        begin
            ctrl.mode = MODE_TEXT;
        end
        ctrl.color   = color_select_reg[3:0];
        ctrl.intense = color_select_reg[4];
        ctrl.pal_sel = color_select_reg[5];
        ctrl.mono    = mode_control_reg[2];
        ctrl.fg      = in_data.byte_b[3:0];
        ctrl.bg      = blink_attr ? {1'b0, in_data.byte_b[6:4]} : in_data.byte_b[7:4];
        ctrl.show    = !blinking || in_data.blink_phase;
        ctrl.cline   = in_data.cursor_here
                       && (in_data.row_in_cell >= cursor_start_reg)
                       && (in_data.row_in_cell <= cursor_end_reg);
    end

    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        logic [1:0] pair;
        if (k < LANES / 2)
        begin : g_pair
            assign pair = bits[LANES-1-2*k -: 2];
        end
        else
        begin : g_nopair
            assign pair = 2'b00;
        end
        cga_lane u_lane (
            .ctrl   (ctrl),
            .hi_bit (bits[LANES-1-k]),
            .pair   (pair),
            .idx    (lane_idx[k])
        );
    end

    logic load_ready;

    assign in_ready = load_ready;

    cga_serial u_serial (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (in_valid && !blank),
        .load_ready (load_ready),
        .load_idx   (lane_idx),
        .load_wide  (ctrl.mode == MODE_HI),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule
